// File: hdl/stereo_odd_poly_shaper_dither_defines.svh
// assertion macros for the checks in the shaper
`ifndef STEREO_ODD_POLY_SHAPER_DITHER_DEFINES_SVH
`define STEREO_ODD_POLY_SHAPER_DITHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SOPSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SOPSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sopsd_pkg.sv
`timescale 1ns / 1ps
package sopsd_pkg;

  // operations of the shared binary64 unit
  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fop_t;

  // request to the shared unit
  typedef struct packed {
    logic start;
    fop_t op;
  } fpu_req_t;

  // configuration register indexes
  localparam logic REG_LEFT_SEED  = 1'b0;
  localparam logic REG_RIGHT_SEED = 1'b1;

  // reset values of the noise words
  localparam logic [31:0] LEFT_SEED_RESET  = 32'd2463534242;
  localparam logic [31:0] RIGHT_SEED_RESET = 32'd88675123;

  // binary64 constants: 1.18e-17 and 5.5e-36
  localparam logic [63:0] C_NOISE  = {1'b0, 11'd966, 52'd3155038238968375};
  localparam logic [63:0] C_DITHER = {1'b0, 11'd905, 52'd3727577594077149};

  // binary32 magnitude pattern of the smallest value not below 1.18e-23
  localparam logic [30:0] F32_THRESHOLD = 31'd426000070;

  localparam logic [32:0] DITHER_CENTER = 33'd2147483647;

  // leading zero count of a 64-bit word (63 for zero)
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] pos;
    pos = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return 6'd63 - pos;
  endfunction

endpackage

// File: hdl/sopsd_fpu.sv
`timescale 1ns / 1ps
module sopsd_fpu (
  input  logic                clk,
  input  logic                rst,
  input  sopsd_pkg::fpu_req_t req,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic                done,
  output logic [63:0]         result
);
  import sopsd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_MNORM,
    F_ALIGN,
    F_NORM,
    F_ROUND
  } fstate_t;

  fstate_t            state;
  logic [63:0]        opa;
  logic [63:0]        opb;
  logic [1:0]         cnt;
  logic [105:0]       prod;
  logic [64:0]        sum;
  logic               rsign;
  logic signed [12:0] rexp;
  logic [52:0]        rman;
  logic               rg;
  logic               rs;

  // operand fields
  logic [10:0] ea, eb;
  logic [52:0] ma, mb;
  assign ea = opa[62:52];
  assign eb = opb[62:52];
  assign ma = {1'b1, opa[51:0]};
  assign mb = {1'b1, opb[51:0]};

  // partial product of the current step
  logic [26:0] pa, pb;
  logic [53:0] pp;
  logic [105:0] pp_shifted;
  always_comb begin
    pa = cnt[1] ? {1'b0, ma[52:27]} : ma[26:0];
    pb = cnt[0] ? {1'b0, mb[52:27]} : mb[26:0];
    pp = pa * pb;
    unique case (cnt)
      2'd0:    pp_shifted = {52'd0, pp};
      2'd3:    pp_shifted = {pp[51:0], 54'd0};
      default: pp_shifted = {25'd0, pp, 27'd0};
    endcase
  end

  // alignment for addition
  logic        a_big;
  logic [10:0] ebig, dexp;
  logic [63:0] big_m, small_m, small_sh, small_mask;
  logic        stk;
  logic        sub;
  always_comb begin
    a_big      = opa[62:0] >= opb[62:0];
    ebig       = a_big ? ea : eb;
    dexp       = a_big ? (ea - eb) : (eb - ea);
    big_m      = a_big ? {ma, 11'd0} : {mb, 11'd0};
    small_m    = a_big ? {mb, 11'd0} : {ma, 11'd0};
    sub        = opa[63] ^ opb[63];
    small_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << dexp[5:0]);
    if (dexp > 11'd63) begin
      small_sh = 64'd0;
      stk      = 1'b1;
    end else begin
      small_sh   = small_m >> dexp[5:0];
      stk        = |(small_m & small_mask);
    end
    small_sh[0] = small_sh[0] | stk;
  end

  // normalization after addition
  logic [5:0]  lz;
  logic [63:0] nsum;
  always_comb begin
    lz   = lzc64(sum[63:0]);
    nsum = sum[63:0] << lz;
  end

  // round to nearest even
  logic [53:0]        rnd;
  logic signed [12:0] fexp;
  always_comb begin
    rnd  = {1'b0, rman} + {53'd0, (rg & (rs | rman[0]))};
    fexp = rnd[53] ? (rexp + 13'sd1) : rexp;
  end

  // completion flag for the next cycle
  logic special;
  logic done_next;
  always_comb begin
    special   = (a[62:52] == 11'h7FF) || (b[62:52] == 11'h7FF) ||
                (a[62:52] == 11'd0) || (b[62:52] == 11'd0);
    done_next = ((state == F_IDLE) && req.start && special) ||
                ((state == F_NORM) && (sum == 65'd0)) || (state == F_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            opa <= a;
            opb <= b;
            cnt <= 2'd0;
            prod <= 106'd0;
            if (req.op == FOP_MUL) begin
              if (a[62:52] == 11'h7FF || b[62:52] == 11'h7FF) begin
                result <= {a[63] ^ b[63], 11'h7FF, 52'd0};
              end else if (a[62:52] == 11'd0 || b[62:52] == 11'd0) begin
                result <= {a[63] ^ b[63], 63'd0};
              end else begin
                state <= F_MUL;
              end
            end else begin
              if (a[62:52] == 11'h7FF || b[62:52] == 11'd0) begin
                result <= a;
              end else if (b[62:52] == 11'h7FF || a[62:52] == 11'd0) begin
                result <= b;
              end else begin
                state <= F_ALIGN;
              end
            end
          end
        end
        // four partial products into the accumulator
        F_MUL: begin
          prod <= prod + pp_shifted;
          cnt  <= cnt + 2'd1;
          if (cnt == 2'd3) state <= F_MNORM;
        end
        F_MNORM: begin
          rsign <= opa[63] ^ opb[63];
          if (prod[105]) begin
            rman <= prod[105:53];
            rg   <= prod[52];
            rs   <= |prod[51:0];
            rexp <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 13'sd1022;
          end else begin
            rman <= prod[104:52];
            rg   <= prod[51];
            rs   <= |prod[50:0];
            rexp <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 13'sd1023;
          end
          state <= F_ROUND;
        end
        F_ALIGN: begin
          sum   <= sub ? ({1'b0, big_m} - {1'b0, small_sh})
                       : ({1'b0, big_m} + {1'b0, small_sh});
          rsign <= a_big ? opa[63] : opb[63];
          rexp  <= $signed({2'b00, ebig});
          state <= F_NORM;
        end
        F_NORM: begin
          if (sum == 65'd0) begin
            result <= 64'd0;
            state  <= F_IDLE;
          end else if (sum[64]) begin
            rman  <= sum[64:12];
            rg    <= sum[11];
            rs    <= |sum[10:0];
            rexp  <= rexp + 13'sd1;
            state <= F_ROUND;
          end else begin
            rman  <= nsum[63:11];
            rg    <= nsum[10];
            rs    <= |nsum[9:0];
            rexp  <= rexp - $signed({7'd0, lz});
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          if (fexp >= 13'sd2047) begin
            result <= {rsign, 11'h7FF, 52'd0};
          end else if (fexp <= 13'sd0) begin
            result <= {rsign, 63'd0};
          end else if (rnd[53]) begin
            result <= {rsign, fexp[10:0], 52'd0};
          end else begin
            result <= {rsign, fexp[10:0], rnd[51:0]};
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/stereo_odd_poly_shaper_dither.sv
`timescale 1ns / 1ps
// an accepted request is worked one channel at a time, left then right;
// a channel takes six products, five sums and the control steps LOAD, EXP, PACK and NEXT,
// one product more when the sample is replaced by noise; a NaN sample skips the unit
// zero or infinite operands finish a product or sum without the multiply or add steps
// no new request is taken until the last result has moved into the output register, which frees the core
// reset: synchronous, active high; noise words take their seed reset values
`include "stereo_odd_poly_shaper_dither_defines.svh"
module stereo_odd_poly_shaper_dither (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [31:0] left_sample,
  input  logic [31:0] right_sample,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] left_result,
  output logic [31:0] right_result
);
  import sopsd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_XN, ST_X2, ST_X3, ST_Y1, ST_X5, ST_Y2, ST_X7,
    ST_Y3, ST_X9, ST_Y4, ST_EXP, ST_DITH, ST_SUM, ST_PACK, ST_NEXT, ST_OUT
  } state_t;

  state_t            state;
  logic              ch;
  logic              waiting;
  logic [31:0]       lin, rin;
  logic [31:0]       lword, rword;
  logic [31:0]       lres, rres;
  logic [63:0]       x, x2, p, y;
  logic signed [8:0] e;

  // unsigned 32-bit magnitude to binary64
  function automatic logic [63:0] u2d(input logic s, input logic [31:0] m);
    logic [5:0]  lzv;
    logic [31:0] nm;
    lzv = lzc64({m, 32'd0});
    nm  = m << lzv[4:0];
    if (m == 32'd0) return 64'd0;
    return {s, 11'd1054 - {5'd0, lzv}, nm[30:0], 21'd0};
  endfunction

  // binary64 to binary32, round to nearest even
  function automatic logic [31:0] d2f(input logic [63:0] d);
    logic signed [12:0] be;
    logic [24:0]        m;
    be = $signed({2'b00, d[62:52]}) - 13'sd896;
    m  = {2'b01, d[51:29]} + {24'd0, d[28] & ((|d[27:0]) | d[29])};
    if (m[24]) be = be + 13'sd1;
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0 || be <= 13'sd0) return {d[63], 31'd0};
    if (be >= 13'sd255) return {d[63], 8'hFF, 23'd0};
    return {d[63], be[7:0], m[24] ? 23'd0 : m[22:0]};
  endfunction

  // exact scaling by a power of two
  function automatic logic [63:0] scl(input logic [63:0] v, input logic signed [9:0] k);
    logic signed [12:0] ne;
    ne = $signed({2'b00, v[62:52]}) + 13'(k);
    if (v[62:52] == 11'd0 || v[62:52] == 11'h7FF) return v;
    return {v[63], ne[10:0], v[51:0]};
  endfunction

  function automatic logic [31:0] xs(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // current channel
  logic [31:0] cur, word, wnew, f32y;
  logic        is_nan, below;
  logic [32:0] diff;
  logic [31:0] dmag;
  always_comb begin
    cur    = ch ? rin : lin;
    word   = ch ? rword : lword;
    wnew   = xs(word);
    is_nan = (cur[30:23] == 8'hFF) && (cur[22:0] != 23'd0);
    below  = cur[30:0] < F32_THRESHOLD;
    f32y   = d2f(y);
    diff   = {1'b0, wnew} - DITHER_CENTER;
    dmag   = diff[32] ? 32'(-diff) : diff[31:0];
  end

  // shared unit request and operands
  fpu_req_t    req;
  logic [63:0] fa, fb, fres;
  logic        fdone;
  logic        op_state;
  always_comb begin
    op_state = 1'b1;
    req.op   = FOP_MUL;
    fa       = x;
    fb       = x;
    unique case (state)
      ST_XN:   begin fa = u2d(1'b0, word); fb = C_NOISE; end
      ST_X2:   ;
      ST_X3:   fa = x2;
      ST_Y1:   begin req.op = FOP_ADD; fb = scl(p, -10'sd2); end
      ST_X5:   begin fa = p; fb = x2; end
      ST_Y2:   begin req.op = FOP_ADD; fa = y; fb = scl(p, -10'sd3); end
      ST_X7:   begin fa = p; fb = x2; end
      ST_Y3:   begin req.op = FOP_ADD; fa = y; fb = scl(p, -10'sd4); end
      ST_X9:   begin fa = p; fb = x2; end
      ST_Y4:   begin req.op = FOP_ADD; fa = y; fb = scl(p, -10'sd5); end
      ST_DITH: begin fa = p; fb = C_DITHER; end
      ST_SUM:  begin
        req.op = FOP_ADD;
        fa     = y;
        fb     = scl(p, 10'(e) + 10'sd62);
      end
      default: op_state = 1'b0;
    endcase
    req.start = op_state && !waiting;
  end

  sopsd_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (fa),
    .b      (fb),
    .done   (fdone),
    .result (fres)
  );

  assign sample_stall = (state != ST_IDLE);

  // sequencer, noise words and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      waiting      <= 1'b0;
      ch           <= 1'b0;
      result_valid <= 1'b0;
      lword        <= LEFT_SEED_RESET;
      rword        <= RIGHT_SEED_RESET;
    end else begin
      if (result_valid && !result_stall && state != ST_OUT) result_valid <= 1'b0;
      if (req.start) waiting <= 1'b1;
      if (cfg_write) begin
        if (cfg_index == REG_LEFT_SEED) lword <= cfg_data;
        if (cfg_index == REG_RIGHT_SEED) rword <= cfg_data;
      end
      if (op_state && fdone) waiting <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            lin   <= left_sample;
            rin   <= right_sample;
            ch    <= 1'b0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (is_nan) begin
            if (ch) rres <= cur | 32'h0040_0000;
            else lres <= cur | 32'h0040_0000;
            if (ch) rword <= wnew;
            else lword <= wnew;
            state <= ST_NEXT;
          end else if (below) begin
            state <= ST_XN;
          end else begin
            x     <= {cur[31], (cur[30:23] == 8'hFF) ? 11'h7FF : {3'd0, cur[30:23]} + 11'd896,
                      cur[22:0], 29'd0};
            state <= ST_X2;
          end
        end
        ST_XN:   if (fdone) begin x <= fres;  state <= ST_X2; end
        ST_X2:   if (fdone) begin x2 <= fres; state <= ST_X3; end
        ST_X3:   if (fdone) begin p <= fres;  state <= ST_Y1; end
        ST_Y1:   if (fdone) begin y <= fres;  state <= ST_X5; end
        ST_X5:   if (fdone) begin p <= fres;  state <= ST_Y2; end
        ST_Y2:   if (fdone) begin y <= fres;  state <= ST_X7; end
        ST_X7:   if (fdone) begin p <= fres;  state <= ST_Y3; end
        ST_Y3:   if (fdone) begin y <= fres;  state <= ST_X9; end
        ST_X9:   if (fdone) begin p <= fres;  state <= ST_Y4; end
        ST_Y4:   if (fdone) begin y <= fres;  state <= ST_EXP; end
        // frexp exponent of the shaped value, noise advance, centered word
        ST_EXP: begin
          if (f32y[30:23] == 8'hFF || f32y[30:23] == 8'd0) e <= 9'sd0;
          else e <= $signed({1'b0, f32y[30:23]}) - 9'sd126;
          if (ch) rword <= wnew;
          else lword <= wnew;
          p     <= u2d(diff[32], dmag);
          state <= ST_DITH;
        end
        ST_DITH: if (fdone) begin p <= fres; state <= ST_SUM; end
        ST_SUM:  if (fdone) begin y <= fres; state <= ST_PACK; end
        ST_PACK: begin
          if (ch) rres <= f32y;
          else lres <= f32y;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (ch) begin
            state <= ST_OUT;
          end else begin
            ch    <= 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            left_result  <= lres;
            right_result <= rres;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `SOPSD_ASSERT_NXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "no stall")
  `SOPSD_ASSERT_IMP(a_done_when_waiting, fdone, waiting, "unit finished without a request")
  `SOPSD_ASSERT_IMP(a_idle_not_waiting, !sample_stall, !waiting, "idle with a request open")

endmodule

// File: tb/sv/shaper_checker.sv
`timescale 1ns / 1ps
module shaper_checker
  import sopsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        sample_valid,
  input  logic        sample_stall,
  input  logic [31:0] left_sample,
  input  logic [31:0] right_sample,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] left_result,
  input  logic [31:0] right_result,
  output int          frames_pending,
  output int          mismatch_count
);

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } shaped_frame_t;

  shaped_frame_t expected_frames[$];
  logic [31:0]   left_word;
  logic [31:0]   right_word;

  // exact widening of a binary32 pattern
  function automatic real f32_to_real(input logic [31:0] b);
    logic [63:0] d;
    real v;
    if (b[30:23] == 8'hff) begin
      d = {b[31], 11'h7ff, b[22:0], 29'd0};
    end else if (b[30:23] != 8'd0) begin
      d = {b[31], {3'd0, b[30:23]} + 11'd896, b[22:0], 29'd0};
    end else begin
      v = real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
      if (b[31]) v = -v;
      return v;
    end
    return $bitstoreal(d);
  endfunction

  // round to nearest even binary32, saturating to infinity
  function automatic logic [31:0] real_to_f32(input real v);
    logic [63:0] d;
    logic        sgn;
    logic [30:0] base;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic        rnd;
    int          ex;
    int          sh;
    d = $realtobits(v);
    sgn = d[63];
    if (d[62:52] == 11'h7ff && d[51:0] != 52'd0)
      return {sgn, 8'hff, 1'b1, d[50:29]};
    if ($bitstoreal({1'b0, d[62:0]}) >= 340282356779733661637539395458142568448.0)
      return {sgn, 8'hff, 23'd0};
    if (d[62:52] == 11'd0) return {sgn, 31'd0};
    ex = int'(d[62:52]) - 1023;
    if (ex >= -126) begin
      base = {8'(ex + 127), d[51:29]};
      rnd = (d[28:0] > 29'h10000000) || (d[28:0] == 29'h10000000 && base[0]);
      return {sgn, base + 31'(rnd)};
    end
    sh = -97 - ex;
    if (sh > 54) return {sgn, 31'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    rnd = (rem > half) || (rem == half && q[0]);
    return {sgn, 31'(q + 64'(rnd))};
  endfunction

  // frexp exponent of a binary32 pattern, zero for zero and specials
  function automatic int f32_frexp_exp(input logic [31:0] b);
    int k;
    if (b[30:23] == 8'hff) return 0;
    if (b[30:23] != 8'd0) return int'(b[30:23]) - 126;
    if (b[22:0] == 23'd0) return 0;
    k = -1;
    for (int i = 0; i < 23; i++) if (b[i]) k = i;
    return k - 148;
  endfunction

  function automatic logic [31:0] xorshift_next(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // one channel: denormal replacement, odd polynomial, scaled dither
  function automatic logic [31:0] shape_sample(input logic [31:0] s, input logic [31:0] w_in,
                                               output logic [31:0] w_out);
    real x, x2, x3, x5, x7, x9, y, dith, scale;
    logic [63:0] xb;
    int e;
    w_out = xorshift_next(w_in);
    if (s[30:23] == 8'hff && s[22:0] != 23'd0) return s | 32'h00400000;
    x = f32_to_real(s);
    xb = $realtobits(x);
    if ($bitstoreal({1'b0, xb[62:0]}) < 1.18e-23)
      x = real'(longint'({32'd0, w_in})) * 1.18e-17;
    x2 = x * x;
    x3 = x2 * x;
    x5 = x3 * x2;
    x7 = x5 * x2;
    x9 = x7 * x2;
    y = x + x3 / 4.0;
    y = y + x5 / 8.0;
    y = y + x7 / 16.0;
    y = y + x9 / 32.0;
    e = f32_frexp_exp(real_to_f32(y));
    dith = (real'(longint'({32'd0, w_out})) - 2147483647.0) * 5.5e-36;
    scale = $bitstoreal({1'b0, 11'(e + 62 + 1023), 52'd0});
    return real_to_f32(y + dith * scale);
  endfunction

  assign frames_pending = expected_frames.size();

  // seed writes, accepted requests and result comparison
  always @(posedge clk) begin
    shaped_frame_t exp_f;
    logic [31:0] nl, nr;
    if (rst) begin
      left_word <= LEFT_SEED_RESET;
      right_word <= RIGHT_SEED_RESET;
      expected_frames.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_LEFT_SEED) left_word <= cfg_data;
        else right_word <= cfg_data;
      end else if (sample_valid && !sample_stall) begin
        exp_f.left = shape_sample(left_sample, left_word, nl);
        exp_f.right = shape_sample(right_sample, right_word, nr);
        left_word <= nl;
        right_word <= nr;
        expected_frames.push_back(exp_f);
      end
      if (result_valid && !result_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t unexpected result left %h right %h", $time, left_result,
                   right_result);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_f = expected_frames.pop_front();
          if (exp_f.left !== left_result || exp_f.right !== right_result) begin
            $display("%0t mismatch expected left %h right %h actual left %h right %h",
                     $time, exp_f.left, exp_f.right, left_result, right_result);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import sopsd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_LEFT_SEED;
  logic [31:0] cfg_data = 32'd0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic [31:0] left_sample = 32'd0;
  logic [31:0] right_sample = 32'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] left_result;
  logic [31:0] right_result;
  int          frames_pending;
  int          mismatch_count;
  logic        quiet = 1'b0;
  int          stall_left = 0;

  always #1 clk = ~clk;

  stereo_odd_poly_shaper_dither u_dut (.*);

  shaper_checker u_checker (.*);

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_frame(input logic [31:0] l, input logic [31:0] r);
    @(negedge clk);
    sample_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    sample_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // wait for every frame to come back, then let the pipeline settle
  task automatic drain;
    pause_sender(1);
    while (frames_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_seed(input logic idx, input logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly audio range, some tiny values, some raw patterns
  function automatic logic [31:0] random_sample;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
    if (pick < 8) return {1'($urandom), 8'($urandom_range(0, 50)), 23'($urandom)};
    return $urandom;
  endfunction

  logic [31:0] directed[20] = '{
    32'h00000000, 32'h80000000, 32'h7fc00001, 32'h7f800001, 32'hffffffff,
    32'h7f800000, 32'hff800000, 32'h7f7fffff, 32'hff7fffff, 32'h00000001,
    32'h007fffff, 32'h1964f6c6, 32'h1964f6c5, 32'h3f800000, 32'hbf800000,
    32'h3f000000, 32'h40000000, 32'h3fc00000, 32'h00800000, 32'hc1200000};

  logic [31:0] left_seeds[5] = '{32'd0, 32'hffffffff, 32'd16386, 32'd1, 32'h0};
  logic [31:0] right_seeds[5] = '{32'hffffffff, 32'd0, 32'd16386, 32'h0, 32'd1};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames under the reset seeds
    foreach (directed[i]) send_frame(directed[i], directed[19 - i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 3) begin
        left_seeds[ph] = $urandom;
        right_seeds[ph] = $urandom;
      end
      write_seed(REG_LEFT_SEED, left_seeds[ph]);
      write_seed(REG_RIGHT_SEED, right_seeds[ph]);
      if (ph == 4) quiet <= 1'b1;
      for (int n = 0; n < 250; n++) begin
        send_frame(random_sample(), random_sample());
        if (ph != 4 && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 13));
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/sopsd_pkg.sv
hdl/sopsd_fpu.sv
hdl/stereo_odd_poly_shaper_dither.sv
tb/sv/shaper_checker.sv
tb/sv/tb.sv
